@@ rtl/core/sppa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stadium path sampler package
// Shared constants, register indexes and section codes.
// ----------------------------------------------------------------------------
package sppa_pkg;

	// Default configuration of the block.
	localparam int COORD_WIDTH_DEF   = 24;
	localparam int CORDIC_STAGES_DEF = 16;

	// Fixed field widths.
	localparam int POS_W   = 32;
	localparam int HEAD_W  = 16;
	localparam int PHASE_W = 32;

	// 2*pi in Q.24 and the inverse CORDIC gain in Q.32.
	localparam int TWO_PI_W = 27;
	localparam logic [TWO_PI_W-1:0] TWO_PI_Q24 = 27'd105414357;
	localparam int KINV_W = 32;
	localparam logic [KINV_W-1:0] KINV_Q32 = 32'd2608131496;

	localparam int GUARD_BITS  = 16;
	localparam int ARC_SHIFT   = 25;
	localparam int PHASE_SHIFT = 24;

	// Cycles needed after a register write before derived values are valid.
	localparam int SETTLE_CYCLES = 4;
	localparam int SETTLE_W      = 3;

	// Arctangent of 2^-i as a fraction of a full turn, 2^32 per turn.
	localparam int ATAN_ENTRIES = 24;
	localparam logic [PHASE_W-1:0] ATAN_TURN [0:ATAN_ENTRIES-1] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_CENTER_X,
		CFG_CENTER_Y,
		CFG_STRAIGHT_LENGTH,
		CFG_ARC_RADIUS
	} cfg_index_t;

	// Path sections in order of travel.
	localparam int SEC_W = 2;
	typedef enum logic [SEC_W-1:0] {
		SEC_TOP,
		SEC_RIGHT,
		SEC_BOTTOM,
		SEC_LEFT
	} section_t;

endpackage

@@ rtl/core/sppa_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stadium path configuration
// Holds the path registers and derives radius, lap length and CORDIC seed.
// ----------------------------------------------------------------------------
module sppa_cfg #(
	parameter int CW = sppa_pkg::COORD_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  sppa_pkg::cfg_index_t      cfg_index,
	input  logic [CW-1:0]             cfg_data,
	output logic                      settling,
	output logic signed [CW-1:0]      center_y,
	output logic [CW-2:0]             len,
	output logic [CW-2:0]             r_eff,
	output logic [CW+25:0]            circ,
	output logic [CW+2:0]             lap,
	output logic [CW+2:0]             len_arc,
	output logic [CW+2:0]             len2_arc,
	output logic signed [CW:0]        left_x,
	output logic signed [CW:0]        right_x,
	output logic [CW+14:0]            x0
);
	import sppa_pkg::*;

	localparam int LW     = CW - 1;
	localparam int CIRC_W = LW + TWO_PI_W;
	localparam int ARC_W  = LW + 2;
	localparam int LAP_W  = LW + 4;
	localparam int KP_W   = LW + KINV_W;

	logic signed [CW-1:0] cx_q, cy_q;
	logic [LW-1:0]        len_q, rad_q, r_eff_q;
	logic [SETTLE_W-1:0]  settle_q;
	logic [CIRC_W-1:0]    circ_q;
	logic [ARC_W-1:0]     arc_q;
	logic [LAP_W-1:0]     lap_q, len_arc_q, len2_arc_q;
	logic signed [CW:0]   left_x_q, right_x_q;
	logic [KP_W-1:0]      kprod;
	logic [CIRC_W:0]      arc_sum;
	logic [LW+15:0]       x0_q;

	// Register writes; the settle counter blocks items until derived values catch up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			len_q    <= LW'(25600);
			rad_q    <= LW'(12800);
			settle_q <= SETTLE_W'(SETTLE_CYCLES);
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_CENTER_X:        cx_q  <= cfg_data;
					CFG_CENTER_Y:        cy_q  <= cfg_data;
					CFG_STRAIGHT_LENGTH: len_q <= cfg_data[LW-1:0];
					CFG_ARC_RADIUS:      rad_q <= cfg_data[LW-1:0];
				endcase
				settle_q <= SETTLE_W'(SETTLE_CYCLES);
			end else if (settle_q != '0) begin
				settle_q <= settle_q - SETTLE_W'(1);
			end
		end
	end

	assign kprod   = KP_W'(r_eff_q) * KP_W'(KINV_Q32);
	assign arc_sum = (CIRC_W+1)'(circ_q) + ((CIRC_W+1)'(1) << (ARC_SHIFT - 1));

	// Derived values, one dependent step per cycle.
	always_ff @(posedge clk) begin
		r_eff_q    <= (rad_q == '0) ? LW'(1) : rad_q;
		left_x_q   <= (CW+1)'(cx_q) - (CW+1)'(len_q >> 1);
		circ_q     <= CIRC_W'(r_eff_q) * CIRC_W'(TWO_PI_Q24);
		x0_q       <= kprod[KP_W-1:GUARD_BITS];
		right_x_q  <= left_x_q + (CW+1)'(len_q);
		arc_q      <= arc_sum[ARC_W+ARC_SHIFT-1:ARC_SHIFT];
		lap_q      <= (LAP_W'(len_q) << 1) + (LAP_W'(arc_q) << 1);
		len_arc_q  <= LAP_W'(len_q) + LAP_W'(arc_q);
		len2_arc_q <= (LAP_W'(len_q) << 1) + LAP_W'(arc_q);
	end

	assign settling = (settle_q != '0);
	assign center_y = cy_q;
	assign len      = len_q;
	assign r_eff    = r_eff_q;
	assign circ     = circ_q;
	assign lap      = lap_q;
	assign len_arc  = len_arc_q;
	assign len2_arc = len2_arc_q;
	assign left_x   = left_x_q;
	assign right_x  = right_x_q;
	assign x0       = x0_q;

endmodule

@@ rtl/core/sppa_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stadium path front end
// Reduces the position modulo the lap length and selects the section.
// ----------------------------------------------------------------------------
module sppa_front #(
	parameter int CW = sppa_pkg::COORD_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic signed [31:0]       position,
	input  logic [CW+2:0]            lap,
	input  logic [CW-2:0]            len,
	input  logic [CW+2:0]            len_arc,
	input  logic [CW+2:0]            len2_arc,
	output logic                     item_valid,
	output sppa_pkg::section_t       item_sec,
	output logic [CW+2:0]            item_dist
);
	import sppa_pkg::*;

	localparam int LAP_W = CW + 3;

	logic               v_s   [0:POS_W];
	logic               neg_s [0:POS_W];
	logic [LAP_W-1:0]   rem_s [0:POS_W];
	logic [POS_W-1:0]   dvd_s [0:POS_W];

	logic               mod_v_s33, cls_v_s34;
	logic [LAP_W-1:0]   mod_s_s33, cls_dist_s34;
	section_t           cls_sec_s34;

	// Entry stage: magnitude and sign of the position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= accept;
		end
	end

	always_ff @(posedge clk) begin
		dvd_s[0] <= position[POS_W-1] ? POS_W'(-position) : POS_W'(position);
		neg_s[0] <= position[POS_W-1];
		rem_s[0] <= '0;
	end

	// Restoring remainder, one dividend bit per stage.
	for (genvar k = 0; k < POS_W; k++) begin : g_mod
		logic [LAP_W:0] trial;
		logic           ge;

		assign trial = {rem_s[k], dvd_s[k][POS_W-1]};
		assign ge    = (trial >= {1'b0, lap});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? LAP_W'(trial - {1'b0, lap}) : trial[LAP_W-1:0];
			dvd_s[k+1] <= dvd_s[k] << 1;
			neg_s[k+1] <= neg_s[k];
		end
	end

	// Floor modulo: a negative position with a remainder folds back from the lap end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_v_s33 <= 1'b0;
			cls_v_s34 <= 1'b0;
		end else begin
			mod_v_s33 <= v_s[POS_W];
			cls_v_s34 <= mod_v_s33;
		end
	end

	always_ff @(posedge clk) begin
		mod_s_s33 <= (neg_s[POS_W] && rem_s[POS_W] != '0) ? lap - rem_s[POS_W]
		                                                  : rem_s[POS_W];
	end

	// Section selection and the distance into that section.
	logic [LAP_W:0] t_ext;
	logic           on_top, on_bottom, on_left;

	assign t_ext     = {1'b0, mod_s_s33} - {1'b0, len_arc};
	assign on_top    = (mod_s_s33 < LAP_W'(len));
	assign on_bottom = !on_top && !t_ext[LAP_W] && (t_ext[LAP_W-1:0] < LAP_W'(len));
	assign on_left   = (mod_s_s33 >= len2_arc);

	always_ff @(posedge clk) begin
		if (on_top) begin
			cls_sec_s34  <= SEC_TOP;
			cls_dist_s34 <= mod_s_s33;
		end else if (on_bottom) begin
			cls_sec_s34  <= SEC_BOTTOM;
			cls_dist_s34 <= t_ext[LAP_W-1:0];
		end else if (on_left) begin
			cls_sec_s34  <= SEC_LEFT;
			cls_dist_s34 <= mod_s_s33 - len2_arc;
		end else begin
			cls_sec_s34  <= SEC_RIGHT;
			cls_dist_s34 <= mod_s_s33 - LAP_W'(len);
		end
	end

	assign item_valid = cls_v_s34;
	assign item_sec   = cls_sec_s34;
	assign item_dist  = cls_dist_s34;

endmodule

@@ rtl/core/sppa_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stadium path item queue
// Two-entry queue between the front and back ends; drains every cycle.
// ----------------------------------------------------------------------------
module sppa_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         out_valid,
	output logic [W-1:0] dout
);
	localparam int DEPTH = 2;
	localparam int PTR_W = 1;
	localparam int CNT_W = 2;

	logic [W-1:0]     mem_q [0:DEPTH-1];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	// The back end always takes a beat, so any held entry is popped.
	assign pop       = (cnt_q != '0);
	assign out_valid = pop;
	assign dout      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && cnt_q == CNT_W'(DEPTH)))
		else $error("item queue written while full");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("item queue count out of range");

	a_push_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cnt_q == '0) |=> out_valid)
		else $error("beat pushed into empty queue not offered");

endmodule

@@ rtl/core/sppa_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stadium path back end
// Angle division, CORDIC rotation and final point assembly with saturation.
// ----------------------------------------------------------------------------
module sppa_back #(
	parameter int CW = sppa_pkg::COORD_WIDTH_DEF,
	parameter int CS = sppa_pkg::CORDIC_STAGES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  sppa_pkg::section_t       in_sec,
	input  logic [CW+2:0]            in_dist,
	input  logic [CW-2:0]            r_eff,
	input  logic [CW+25:0]           circ,
	input  logic [CW+14:0]           x0,
	input  logic signed [CW-1:0]     center_y,
	input  logic signed [CW:0]       left_x,
	input  logic signed [CW:0]       right_x,
	output logic                     done,
	output logic signed [CW-1:0]     point_x,
	output logic signed [CW-1:0]     point_y,
	output logic [15:0]              heading
);
	import sppa_pkg::*;

	localparam int LW     = CW - 1;
	localparam int ARC_W  = LW + 2;
	localparam int LAP_W  = LW + 4;
	localparam int CIRC_W = LW + TWO_PI_W;
	localparam int XW     = CW + 17;
	localparam int ZW     = PHASE_W + 1;
	localparam int RW     = XW - GUARD_BITS;
	localparam int PW     = CW + 6;

	localparam logic signed [PW-1:0] SAT_HI = {{(PW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [PW-1:0] SAT_LO = {{(PW-CW+1){1'b1}}, {(CW-1){1'b0}}};
	localparam logic signed [XW-1:0] HALF   = XW'(1) << (GUARD_BITS - 1);
	localparam logic [HEAD_W-1:0] HEAD_TOP    = 16'h0000;
	localparam logic [HEAD_W-1:0] HEAD_BOTTOM = 16'h8000;

	// Angle division pipeline.
	logic               ph_v_s     [0:PHASE_W];
	section_t           ph_sec_s   [0:PHASE_W];
	logic [LAP_W-1:0]   ph_dist_s  [0:PHASE_W];
	logic [CIRC_W-1:0]  ph_rem_s   [0:PHASE_W];
	logic [PHASE_W-1:0] ph_phase_s [0:PHASE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_v_s[0] <= 1'b0;
		end else begin
			ph_v_s[0] <= in_valid;
		end
	end

	// Offset into the arc scaled up so the quotient is a 32-bit turn fraction.
	always_ff @(posedge clk) begin
		ph_sec_s[0]   <= in_sec;
		ph_dist_s[0]  <= in_dist;
		ph_rem_s[0]   <= CIRC_W'({in_dist[ARC_W-1:0], {PHASE_SHIFT{1'b0}}});
		ph_phase_s[0] <= '0;
	end

	for (genvar k = 0; k < PHASE_W; k++) begin : g_phase
		logic [CIRC_W:0] trial;
		logic            ge;

		assign trial = {ph_rem_s[k], 1'b0};
		assign ge    = (trial >= {1'b0, circ});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ph_v_s[k+1] <= 1'b0;
			end else begin
				ph_v_s[k+1] <= ph_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			ph_sec_s[k+1]   <= ph_sec_s[k];
			ph_dist_s[k+1]  <= ph_dist_s[k];
			ph_rem_s[k+1]   <= ge ? CIRC_W'(trial - {1'b0, circ}) : trial[CIRC_W-1:0];
			ph_phase_s[k+1] <= {ph_phase_s[k][PHASE_W-2:0], ge};
		end
	end

	// Heading and rotation angle; quadrants two and three are mirrored.
	logic [PHASE_W-1:0] head32, head_rnd, angle, angle_f;
	logic               flip;

	assign head32   = (ph_sec_s[PHASE_W] == SEC_LEFT) ? ph_phase_s[PHASE_W] + 32'h8000_0000
	                                                  : ph_phase_s[PHASE_W];
	assign head_rnd = head32 + 32'h0000_8000;
	assign angle    = head32 - 32'h4000_0000;
	assign flip     = angle[PHASE_W-1] ^ angle[PHASE_W-2];
	assign angle_f  = {angle[PHASE_W-1] ^ flip, angle[PHASE_W-2:0]};

	logic                 cr_v_s    [0:CS];
	section_t             cr_sec_s  [0:CS];
	logic [LAP_W-1:0]     cr_dist_s [0:CS];
	logic [HEAD_W-1:0]    cr_head_s [0:CS];
	logic                 cr_flip_s [0:CS];
	logic signed [XW-1:0] cr_x_s    [0:CS];
	logic signed [XW-1:0] cr_y_s    [0:CS];
	logic signed [ZW-1:0] cr_z_s    [0:CS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_v_s[0] <= 1'b0;
		end else begin
			cr_v_s[0] <= ph_v_s[PHASE_W];
		end
	end

	always_ff @(posedge clk) begin
		cr_sec_s[0]  <= ph_sec_s[PHASE_W];
		cr_dist_s[0] <= ph_dist_s[PHASE_W];
		cr_head_s[0] <= head_rnd[PHASE_W-1:PHASE_W-HEAD_W];
		cr_flip_s[0] <= flip;
		cr_x_s[0]    <= XW'(x0);
		cr_y_s[0]    <= '0;
		cr_z_s[0]    <= ZW'(signed'(angle_f));
	end

	// Rotation-mode CORDIC, one micro-rotation per stage.
	for (genvar i = 0; i < CS; i++) begin : g_cordic
		logic signed [XW-1:0] xs, ys;
		logic signed [ZW-1:0] at;

		assign xs = cr_x_s[i] >>> i;
		assign ys = cr_y_s[i] >>> i;
		assign at = signed'(ZW'(ATAN_TURN[i]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cr_v_s[i+1] <= 1'b0;
			end else begin
				cr_v_s[i+1] <= cr_v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			cr_sec_s[i+1]  <= cr_sec_s[i];
			cr_dist_s[i+1] <= cr_dist_s[i];
			cr_head_s[i+1] <= cr_head_s[i];
			cr_flip_s[i+1] <= cr_flip_s[i];
			if (!cr_z_s[i][ZW-1]) begin
				cr_x_s[i+1] <= cr_x_s[i] - ys;
				cr_y_s[i+1] <= cr_y_s[i] + xs;
				cr_z_s[i+1] <= cr_z_s[i] - at;
			end else begin
				cr_x_s[i+1] <= cr_x_s[i] + ys;
				cr_y_s[i+1] <= cr_y_s[i] - xs;
				cr_z_s[i+1] <= cr_z_s[i] + at;
			end
		end
	end

	// Round half up out of the guard bits and undo the mirror.
	logic signed [XW-1:0] x_rnd, y_rnd;
	logic signed [RW-1:0] x_int, y_int;

	assign x_rnd = cr_x_s[CS] + HALF;
	assign y_rnd = cr_y_s[CS] + HALF;
	assign x_int = x_rnd[XW-1:GUARD_BITS];
	assign y_int = y_rnd[XW-1:GUARD_BITS];

	logic                 rd_v_s, out_v_q;
	section_t             rd_sec_s;
	logic [LAP_W-1:0]     rd_dist_s;
	logic [HEAD_W-1:0]    rd_head_s;
	logic signed [RW-1:0] rd_cx_s, rd_sy_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			rd_v_s  <= cr_v_s[CS];
			out_v_q <= rd_v_s;
		end
	end

	always_ff @(posedge clk) begin
		rd_sec_s  <= cr_sec_s[CS];
		rd_dist_s <= cr_dist_s[CS];
		rd_head_s <= cr_head_s[CS];
		rd_cx_s   <= cr_flip_s[CS] ? -x_int : x_int;
		rd_sy_s   <= cr_flip_s[CS] ? -y_int : y_int;
	end

	// Point on the selected section, then clamp to the coordinate range.
	logic signed [PW-1:0] px, py;
	logic [HEAD_W-1:0]    hd;
	logic signed [CW-1:0] point_x_q, point_y_q;
	logic [HEAD_W-1:0]    heading_q;

	always_comb begin
		unique case (rd_sec_s)
			SEC_TOP: begin
				px = PW'(left_x) + PW'(rd_dist_s);
				py = PW'(center_y) - PW'(r_eff);
				hd = HEAD_TOP;
			end
			SEC_BOTTOM: begin
				px = PW'(right_x) - PW'(rd_dist_s);
				py = PW'(center_y) + PW'(r_eff);
				hd = HEAD_BOTTOM;
			end
			SEC_RIGHT: begin
				px = PW'(right_x) + PW'(rd_cx_s);
				py = PW'(center_y) + PW'(rd_sy_s);
				hd = rd_head_s;
			end
			SEC_LEFT: begin
				px = PW'(left_x) + PW'(rd_cx_s);
				py = PW'(center_y) + PW'(rd_sy_s);
				hd = rd_head_s;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (px > SAT_HI) begin
			point_x_q <= SAT_HI[CW-1:0];
		end else if (px < SAT_LO) begin
			point_x_q <= SAT_LO[CW-1:0];
		end else begin
			point_x_q <= px[CW-1:0];
		end
		if (py > SAT_HI) begin
			point_y_q <= SAT_HI[CW-1:0];
		end else if (py < SAT_LO) begin
			point_y_q <= SAT_LO[CW-1:0];
		end else begin
			point_y_q <= py[CW-1:0];
		end
		heading_q <= hd;
	end

	assign done    = out_v_q;
	assign point_x = point_x_q;
	assign point_y = point_y_q;
	assign heading = heading_q;

endmodule

@@ rtl/core/stadium_path_point_from_arc_length.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stadium path point from arc length
// Maps an arc-length position on a stadium-shaped lap to a point and heading.
// ----------------------------------------------------------------------------
// Usage: pulse start with a position whenever busy is low; a new position may
// be given in every cycle. Each one produces exactly one result, marked by a
// single-cycle done pulse, in the order of the starts. The receiver cannot
// stall the block and must take each result in its done cycle. Each position
// passes through the 32-stage lap modulo, the 32-stage angle division and the
// CORDIC pipeline. After reset and after any register write busy stays high
// while the lap length and CORDIC seed are recomputed; registers may only be
// written when no result is outstanding.
// ----------------------------------------------------------------------------
module stadium_path_point_from_arc_length #(
	parameter int COORD_WIDTH   = sppa_pkg::COORD_WIDTH_DEF,
	parameter int CORDIC_STAGES = sppa_pkg::CORDIC_STAGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [31:0]          position,
	output logic                        done,
	output logic signed [COORD_WIDTH-1:0] point_x,
	output logic signed [COORD_WIDTH-1:0] point_y,
	output logic [15:0]                 heading,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  sppa_pkg::cfg_index_t        cfg_index,
	input  logic [COORD_WIDTH-1:0]      cfg_data
);
	import sppa_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int LAP_W = CW + 3;
	localparam int ITEM_W = SEC_W + LAP_W;

	logic                 settling, accept;
	logic signed [CW-1:0] center_y;
	logic [CW-2:0]        len, r_eff;
	logic [CW+25:0]       circ;
	logic [LAP_W-1:0]     lap, len_arc, len2_arc;
	logic signed [CW:0]   left_x, right_x;
	logic [CW+14:0]       x0;

	logic                 fr_valid, q_valid;
	section_t             fr_sec;
	logic [LAP_W-1:0]     fr_dist;
	logic [ITEM_W-1:0]    q_item;

	// Registers are always writable; items wait while derived values settle.
	assign cfg_ready = 1'b1;
	assign busy      = settling;
	assign accept    = start && !settling;

	sppa_cfg #(.CW(CW)) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.settling (settling),
		.center_y (center_y),
		.len      (len),
		.r_eff    (r_eff),
		.circ     (circ),
		.lap      (lap),
		.len_arc  (len_arc),
		.len2_arc (len2_arc),
		.left_x   (left_x),
		.right_x  (right_x),
		.x0       (x0)
	);

	sppa_front #(.CW(CW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.position  (position),
		.lap       (lap),
		.len       (len),
		.len_arc   (len_arc),
		.len2_arc  (len2_arc),
		.item_valid(fr_valid),
		.item_sec  (fr_sec),
		.item_dist (fr_dist)
	);

	sppa_fifo #(.W(ITEM_W)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fr_valid),
		.din      ({fr_sec, fr_dist}),
		.out_valid(q_valid),
		.dout     (q_item)
	);

	sppa_back #(.CW(CW), .CS(CORDIC_STAGES)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(q_valid),
		.in_sec  (section_t'(q_item[ITEM_W-1:LAP_W])),
		.in_dist (q_item[LAP_W-1:0]),
		.r_eff   (r_eff),
		.circ    (circ),
		.x0      (x0),
		.center_y(center_y),
		.left_x  (left_x),
		.right_x (right_x),
		.done    (done),
		.point_x (point_x),
		.point_y (point_y),
		.heading (heading)
	);

endmodule

@@ verif/tb_stadium_path_point_from_arc_length.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stadium path sampler testbench
// Feeds arc-length positions over several path settings and idle patterns,
// predicts point and heading for each beat and checks every done beat in order.
// ----------------------------------------------------------------------------
module tb_stadium_path_point_from_arc_length;
	import sppa_pkg::*;

	localparam int CW        = COORD_WIDTH_DEF;
	localparam int MAX_CYCLE = 400000;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [HEAD_W-1:0]    h;
	} path_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [POS_W-1:0] position = '0;
	logic cfg_valid = 1'b0;
	cfg_index_t cfg_index = CFG_CENTER_X;
	logic [CW-1:0] cfg_data = '0;
	logic busy, done, cfg_ready;
	logic signed [CW-1:0] point_x, point_y;
	logic [HEAD_W-1:0] heading;

	// Shadow of the path registers.
	longint cx_m = 0, cy_m = 0, len_m = 25600, rad_m = 12800;

	logic [POS_W-1:0] position_q [$];
	path_point_t      expected_q [$];
	int idle_pct = 0;
	bit hold_off = 1'b0;
	int errors = 0, checked = 0, cycles = 0;

	stadium_path_point_from_arc_length u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.position(position), .done(done), .point_x(point_x),
		.point_y(point_y), .heading(heading), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint clamp_coord(longint v);
		longint hi, lo;
		hi = (longint'(1) << (CW - 1)) - 1;
		lo = -hi - 1;
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	function automatic longint half_arc_len();
		longint r;
		r = (rad_m > 0) ? rad_m : 1;
		return (r * longint'(TWO_PI_Q24) + (longint'(1) << 24)) >>> ARC_SHIFT;
	endfunction

	// Appends a position to the tail of the pending queue.
	function automatic void enqueue_pos(logic [POS_W-1:0] v);
		position_q.insert(position_q.size(), v);
	endfunction

	// Point and heading at an arc-length position under the shadow registers.
	function automatic path_point_t predict_point(logic signed [POS_W-1:0] pos);
		longint r, len, arc, lap, s, lx, rx, px, py, off, x, y, z, nx;
		logic [63:0] circ, rem;
		logic [31:0] phase, head32, ang;
		bit flip, on_left;
		path_point_t p;
		r = (rad_m > 0) ? rad_m : 1;
		len = len_m;
		circ = 64'(r) * 64'(TWO_PI_Q24);
		arc = half_arc_len();
		lap = 2 * len + 2 * arc;
		s = longint'(pos) % lap;
		if (s < 0)
			s += lap;
		lx = cx_m - (len >>> 1);
		rx = lx + len;
		if (s < len) begin
			px = lx + s;
			py = cy_m - r;
			p.h = 16'd0;
		end else if (s - len - arc >= 0 && s - len - arc < len) begin
			px = rx - (s - len - arc);
			py = cy_m + r;
			p.h = 16'd32768;
		end else begin
			on_left = (s >= 2 * len + arc);
			off = on_left ? s - 2 * len - arc : s - len;
			// Restoring division gives the angle as a fraction of a turn.
			rem = 64'(off) << PHASE_SHIFT;
			phase = '0;
			for (int i = 0; i < 32; i++) begin
				rem = rem << 1;
				phase = phase << 1;
				if (rem >= circ) begin
					rem = rem - circ;
					phase[0] = 1'b1;
				end
			end
			head32 = on_left ? phase + 32'h8000_0000 : phase;
			p.h = 16'((33'(head32) + 33'h8000) >> 16);
			// Rotation-mode CORDIC, folded into the right half plane.
			ang = head32 - 32'h4000_0000;
			flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
			if (flip)
				ang = ang + 32'h8000_0000;
			z = longint'(signed'(ang));
			x = longint'((64'(r) * 64'(KINV_Q32)) >> (32 - GUARD_BITS));
			y = 0;
			for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z = z - longint'(ATAN_TURN[i]);
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z = z + longint'(ATAN_TURN[i]);
				end
				x = nx;
			end
			x = (x + (longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS;
			y = (y + (longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS;
			if (flip) begin
				x = -x;
				y = -y;
			end
			px = (on_left ? lx : rx) + x;
			py = cy_m + y;
		end
		p.x = CW'(clamp_coord(px));
		p.y = CW'(clamp_coord(py));
		return p;
	endfunction

	// Driver: offers queued positions and records the expected point per beat.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (start && !busy)
			expected_q.insert(expected_q.size(), predict_point(position));
		if (!start || !busy) begin
			if (position_q.size() > 0 && !hold_off && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				position <= position_q.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every done beat is compared with the oldest expectation.
	always @(posedge clk) begin
		if (done) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d h=%0d", $time,
					point_x, point_y, heading);
				errors++;
			end else begin
				path_point_t e;
				e = expected_q.pop_front();
				checked++;
				if (point_x !== e.x) begin
					$display("%0t: point_x expected %0d actual %0d", $time, e.x, point_x);
					errors++;
				end
				if (point_y !== e.y) begin
					$display("%0t: point_y expected %0d actual %0d", $time, e.y, point_y);
					errors++;
				end
				if (heading !== e.h) begin
					$display("%0t: heading expected %0d actual %0d", $time, e.h, heading);
					errors++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		if (cycles > MAX_CYCLE) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic write_reg(cfg_index_t idx, logic [CW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_CENTER_X:        cx_m = longint'(signed'(val));
			CFG_CENTER_Y:        cy_m = longint'(signed'(val));
			CFG_STRAIGHT_LENGTH: len_m = longint'(val[CW-2:0]);
			CFG_ARC_RADIUS:      rad_m = longint'(val[CW-2:0]);
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (position_q.size() > 0 || start || expected_q.size() > 0);
	endtask

	// Section boundaries and extreme positions for the current path.
	task automatic queue_boundaries();
		longint len, arc, lap;
		len = len_m;
		arc = half_arc_len();
		lap = 2 * len + 2 * arc;
		enqueue_pos(32'(0));
		enqueue_pos(32'(len - 1));
		enqueue_pos(32'(len));
		enqueue_pos(32'(len + arc / 4));
		enqueue_pos(32'(len + arc / 2));
		enqueue_pos(32'(len + arc - 1));
		enqueue_pos(32'(len + arc));
		enqueue_pos(32'(2 * len + arc - 1));
		enqueue_pos(32'(2 * len + arc));
		enqueue_pos(32'(2 * len + arc + arc / 2));
		enqueue_pos(32'(2 * len + arc + 3 * arc / 4));
		enqueue_pos(32'(lap - 1));
		enqueue_pos(32'(lap));
		enqueue_pos(32'(-1));
		enqueue_pos(32'(-lap - 3));
		enqueue_pos(32'h7FFF_FFFF);
		enqueue_pos(32'h8000_0000);
	endtask

	task automatic queue_random(int n);
		longint lap, v;
		lap = 2 * len_m + 2 * half_arc_len();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0) begin
				enqueue_pos($urandom);
			end else begin
				v = longint'($urandom) % (5 * lap) - 2 * lap;
				enqueue_pos(32'(v));
			end
		end
	endtask

	// Path settings per phase: centre x, centre y, straight, radius.
	logic [CW-1:0] set_cx [0:6] = '{24'd0, 24'h7FFFFF, 24'h800000, 24'hFFF380,
		24'd1000, 24'h7FF000, 24'h123456};
	logic [CW-1:0] set_cy [0:6] = '{24'd0, 24'h7FFFFF, 24'h800000, 24'd5000,
		24'hFFFF00, 24'h000100, 24'h800100};
	logic [CW-1:0] set_len [0:6] = '{24'd25600, 24'd0, 24'h7FFFFF, 24'd101,
		24'hC00333, 24'd1, 24'd77777};
	logic [CW-1:0] set_rad [0:6] = '{24'd12800, 24'd1, 24'h7FFFFF, 24'd0,
		24'h800005, 24'd3000, 24'd250000};
	int phase_idle [0:6] = '{0, 72, 0, 24, 0, 72, 24};

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		queue_boundaries();
		for (int ph = 0; ph < 7; ph++) begin
			if (ph > 0) begin
				wait_drained();
				write_reg(CFG_CENTER_X, set_cx[ph]);
				write_reg(CFG_CENTER_Y, set_cy[ph]);
				write_reg(CFG_STRAIGHT_LENGTH, set_len[ph]);
				write_reg(CFG_ARC_RADIUS, set_rad[ph]);
				queue_boundaries();
			end
			idle_pct = phase_idle[ph];
			queue_random(180);
			// Once, stop offering until the pipeline has emptied.
			if (ph == 3) begin
				repeat (40) @(posedge clk);
				hold_off = 1'b1;
				while (expected_q.size() > 0 || start)
					@(posedge clk);
				hold_off = 1'b0;
			end
		end
		wait_drained();
		repeat (120) @(posedge clk);
		$display("Checked %0d results over seven path settings, covering every section,",
			checked);
		$display("lap wrap, saturation and idle rates from none to 72 per cent.");
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/sppa_pkg.sv
rtl/core/sppa_cfg.sv
rtl/core/sppa_front.sv
rtl/core/sppa_fifo.sv
rtl/core/sppa_back.sv
rtl/core/stadium_path_point_from_arc_length.sv
verif/tb_stadium_path_point_from_arc_length.sv
